>>> hdl/lrb_pkg.sv
package lrb_pkg;

    localparam int COORD_W = 6;
    // error term spans roughly -2*63 .. +2*63
    localparam int ERR_W = 9;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 16;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [ERR_W-1:0] err_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture a new segment and set up the stepper
        logic step;   // advance one pixel along the major axis
    } lrb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;   // current pixel is the end point
    } lrb_stat_t;

endpackage

>>> hdl/lrb_ctrl.sv
module lrb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  lrb_pkg::lrb_stat_t stat,
    output lrb_pkg::lrb_cmd_t  cmd
);
    import lrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_RUN);
    assign cmd.load = s_valid && s_ready;
    assign cmd.step = m_valid && m_ready && !stat.last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (m_ready && stat.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/lrb_dp.sv
module lrb_dp
(
    input  logic                              clk,
    input  lrb_pkg::lrb_cmd_t                 cmd,
    input  logic [lrb_pkg::IN_TDATA_W-1:0]    seg,
    output lrb_pkg::coord_t                   pixel_x,
    output lrb_pkg::coord_t                   pixel_y,
    output lrb_pkg::lrb_stat_t                stat
);
    import lrb_pkg::*;

    coord_t xs, ys, xe, ye;
    coord_t dx, dy;
    logic   y_major;
    coord_t maj0, maj_end0, mnr0, mnr_end0, dmaj0, dmnr0;

    coord_t maj_reg, maj_next;
    coord_t mnr_reg, mnr_next;
    coord_t maj_end_reg, maj_end_next;
    logic   maj_dec_reg, maj_dec_next;
    logic   mnr_dec_reg, mnr_dec_next;
    logic   y_major_reg, y_major_next;
    err_t   err_reg, err_next;
    err_t   inc_keep_reg, inc_keep_next;
    err_t   inc_step_reg, inc_step_next;

    assign xs = seg[COORD_W-1:0];
    assign ys = seg[2*COORD_W-1:COORD_W];
    assign xe = seg[3*COORD_W-1:2*COORD_W];
    assign ye = seg[4*COORD_W-1:3*COORD_W];

    assign dx      = (xe > xs) ? (xe - xs) : (xs - xe);
    assign dy      = (ye > ys) ? (ye - ys) : (ys - ye);
    assign y_major = (dx < dy);

    assign maj0     = y_major ? ys : xs;
    assign maj_end0 = y_major ? ye : xe;
    assign mnr0     = y_major ? xs : ys;
    assign mnr_end0 = y_major ? xe : ye;
    assign dmaj0    = y_major ? dy : dx;
    assign dmnr0    = y_major ? dx : dy;

    always_comb
    begin
        maj_next      = maj_reg;
        mnr_next      = mnr_reg;
        maj_end_next  = maj_end_reg;
        maj_dec_next  = maj_dec_reg;
        mnr_dec_next  = mnr_dec_reg;
        y_major_next  = y_major_reg;
        err_next      = err_reg;
        inc_keep_next = inc_keep_reg;
        inc_step_next = inc_step_reg;
        if (cmd.load)
        begin
            maj_next      = maj0;
            mnr_next      = mnr0;
            maj_end_next  = maj_end0;
            maj_dec_next  = !(maj_end0 > maj0);
            mnr_dec_next  = !(mnr_end0 > mnr0);
            y_major_next  = y_major;
            inc_keep_next = err_t'({dmnr0, 1'b0});
            inc_step_next = err_t'({dmnr0, 1'b0}) - err_t'({dmaj0, 1'b0});
            err_next      = err_t'({dmnr0, 1'b0}) - err_t'(dmaj0);
        end
        else if (cmd.step)
        begin
            maj_next = maj_dec_reg ? (maj_reg - coord_t'(1)) : (maj_reg + coord_t'(1));
            if (err_reg[ERR_W-1])
            begin
                err_next = err_reg + inc_keep_reg;
            end
            else
            begin
                mnr_next = mnr_dec_reg ? (mnr_reg - coord_t'(1))
                                       : (mnr_reg + coord_t'(1));
                err_next = err_reg + inc_step_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        maj_reg      <= maj_next;
        mnr_reg      <= mnr_next;
        maj_end_reg  <= maj_end_next;
        maj_dec_reg  <= maj_dec_next;
        mnr_dec_reg  <= mnr_dec_next;
        y_major_reg  <= y_major_next;
        err_reg      <= err_next;
        inc_keep_reg <= inc_keep_next;
        inc_step_reg <= inc_step_next;
    end

    assign pixel_x   = y_major_reg ? mnr_reg : maj_reg;
    assign pixel_y   = y_major_reg ? maj_reg : mnr_reg;
    assign stat.last = (maj_reg == maj_end_reg);

endmodule

>>> hdl/line_raster_bresenham.sv
// Bresenham line rasterizer.
// Slave stream: one transaction carries a segment (start and end points).
// Master stream: one transaction per pixel, start point through end point
// inclusive, in drawing order; tlast marks the end point.
// A segment whose major-axis delta is d gives d+1 pixels (1 to 64).
// The first pixel is offered the cycle after the segment is taken.
// Throughput: one pixel per cycle while the receiver is ready; the single
// error accumulator/stepper loop sets this pace.
// One segment is in flight at a time: s_axis_tready is high only when the
// previous segment's last pixel has been taken.
// Receiver stall: the current pixel holds on m_axis_tdata/tlast and the
// stepper waits; nothing is dropped.
// Reset (rst_n low, asynchronous) returns the controller to idle, drops any
// segment in progress and raises s_axis_tready. Datapath registers carry no
// reset; they are loaded on every accepted segment.
module line_raster_bresenham
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
    input  logic [lrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x[5:0], pixel_y[11:6], zero[15:12]
    output logic [lrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // last_pixel
    output logic                               m_axis_tlast
);
    import lrb_pkg::*;

    lrb_cmd_t  cmd;
    lrb_stat_t stat;
    coord_t    pixel_x;
    coord_t    pixel_y;

    lrb_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lrb_dp u_dp
    (
        .clk     (clk),
        .cmd     (cmd),
        .seg     (s_axis_tdata),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .stat    (stat)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2*COORD_W){1'b0}}, pixel_y, pixel_x};
    assign m_axis_tlast = stat.last;

    // a taken segment always produces a pixel next cycle
    a_load_then_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("no pixel after segment accepted");

    // input side closed while pixels are pending
    a_one_segment: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("segment accepted while drawing");

    // the end point closes the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("pixel emitted after end point");

    // non-final pixel taken: stepper advances, end point not yet reached stays consistent
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tdata != $past(m_axis_tdata))))
        else $error("pixel did not advance");

endmodule
